// File: rtl/qfbfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfbfa_pkg
// shared types, codes and helpers of the queue family best-fit allocator
// ----------------------------------------------------------------------------
package qfbfa_pkg;

    localparam int MAX_FAMILIES_DEF = 8;
    localparam int MAX_REQUESTS_DEF = 16;
    localparam int PC_W             = 6;

    // opcodes
    localparam logic [1:0] OP_LOAD_FAMILY  = 2'd0;
    localparam logic [1:0] OP_LOAD_REQUEST = 2'd1;
    localparam logic [1:0] OP_RESOLVE      = 2'd2;

    // request types
    localparam logic [1:0] TYPE_GRAPHICS = 2'd0;
    localparam logic [1:0] TYPE_COMPUTE  = 2'd1;
    localparam logic [1:0] TYPE_TRANSFER = 2'd2;
    localparam logic [1:0] TYPE_INVALID  = 2'd3;

    // result status
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NO_FAMILY = 2'd1;
    localparam logic [1:0] STS_BAD_TYPE  = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] family_flags;
        logic [7:0]  family_queue_count;
        logic [1:0]  request_type;
        logic        prefer_dedicated;
    } item_t;

    typedef struct packed {
        logic [3:0] request_index;
        logic [1:0] queue_role;
        logic [2:0] family_index;
        logic [7:0] slot_index;
        logic [1:0] status;
        logic       last;
    } result_t;

    typedef struct packed {
        logic       ded;
        logic [1:0] rtype;
    } req_entry_t;

    typedef struct packed {
        logic [2:0] family;
        logic [7:0] slot;
        logic [1:0] status;
    } res_entry_t;

    // controller to datapath
    typedef struct packed {
        logic load_fam;
        logic load_req;
        logic clear_claims;
        logic rd;
        logic scan_clear;
        logic scan_en;
        logic commit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic have_reqs;
        logic last_req;
        logic last_fam;
        logic req_ded;
        logic req_skip;
    } dp_sts_t;

    // count of set bits, nibble counts then their sum
    function automatic logic [PC_W-1:0] popcount32(input logic [31:0] v);
        logic [PC_W-1:0] sum;
        logic [2:0]      nib;
        sum = '0;
        for (int k = 0; k < 8; k++)
        begin
            nib = {2'b00, v[4*k]} + {2'b00, v[4*k+1]}
                + {2'b00, v[4*k+2]} + {2'b00, v[4*k+3]};
            sum = sum + PC_W'(nib);
        end
        return sum;
    endfunction

endpackage

// File: rtl/qfbfa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfbfa_dp
// family and request storage, family scan with best-fit tracking, results
// ----------------------------------------------------------------------------
module qfbfa_dp
    import qfbfa_pkg::*;
#(
    parameter int MAX_FAMILIES = MAX_FAMILIES_DEF,
    parameter int MAX_REQUESTS = MAX_REQUESTS_DEF,
    localparam int FAW = (MAX_FAMILIES > 1) ? $clog2(MAX_FAMILIES) : 1,
    localparam int RAW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  item_t          item,
    input  ctrl_cmd_t      cmd,
    input  logic [RAW-1:0] addr,
    input  logic [FAW-1:0] fam_idx,
    output dp_sts_t        sts,
    output result_t        result
);

    localparam int FCW = $clog2(MAX_FAMILIES + 1);
    localparam int RCW = $clog2(MAX_REQUESTS + 1);

    // family store: capability bits and popcount of the full mask
    logic [2:0]      fam_caps_reg [MAX_FAMILIES];
    logic [PC_W-1:0] fam_pc_reg   [MAX_FAMILIES];
    logic [7:0]      fam_cnt_reg  [MAX_FAMILIES];
    logic [7:0]      claimed_reg  [MAX_FAMILIES];

    logic [FCW-1:0] nfam_reg;
    logic [RCW-1:0] nreq_reg;

    req_entry_t req_mem [MAX_REQUESTS];
    res_entry_t res_mem [MAX_REQUESTS];
    req_entry_t req_q_reg;
    res_entry_t res_q_reg;

    // best candidates: with a spare slot, and ignoring capacity
    logic            sp_vld_reg, any_vld_reg;
    logic [FAW-1:0]  sp_idx_reg, any_idx_reg;
    logic [PC_W-1:0] sp_pc_reg, any_pc_reg;
    logic [7:0]      sp_cl_reg, any_cl_reg, sp_cnt_reg, any_cnt_reg;

    logic fam_load_ok, req_load_ok;
    logic cand_has, cand_spare, upd_sp, upd_any;

    logic            sel_vld;
    logic [FAW-1:0]  sel_idx;
    logic [7:0]      sel_cl, sel_cnt, sel_slot;
    logic [FAW+2:0]  sel_idx_wide;
    logic [RAW+3:0]  addr_wide;
    res_entry_t      res_new;

    assign fam_load_ok = cmd.load_fam && (nfam_reg < FCW'(MAX_FAMILIES));
    assign req_load_ok = cmd.load_req && (nreq_reg < RCW'(MAX_REQUESTS));

    // does the scanned family hold the required flag
    always_comb
    begin
        unique case (req_q_reg.rtype)
            TYPE_GRAPHICS: cand_has = fam_caps_reg[fam_idx][0];
            TYPE_COMPUTE:  cand_has = fam_caps_reg[fam_idx][1];
            TYPE_TRANSFER: cand_has = fam_caps_reg[fam_idx][2];
            default:       cand_has = 1'b0;
        endcase
    end

    assign cand_spare = claimed_reg[fam_idx] < fam_cnt_reg[fam_idx];
    assign upd_any = cand_has && (!any_vld_reg || (fam_pc_reg[fam_idx] < any_pc_reg));
    assign upd_sp  = cand_has && cand_spare
                   && (!sp_vld_reg || (fam_pc_reg[fam_idx] < sp_pc_reg));

    // resolution of the current request
    assign sel_vld = sp_vld_reg || any_vld_reg;
    assign sel_idx = sp_vld_reg ? sp_idx_reg : any_idx_reg;
    assign sel_cl  = sp_vld_reg ? sp_cl_reg  : any_cl_reg;
    assign sel_cnt = sp_vld_reg ? sp_cnt_reg : any_cnt_reg;
    assign sel_idx_wide = (FAW + 3)'(sel_idx);

    always_comb
    begin
        if (sel_cnt == 8'd0)
            sel_slot = 8'd0;
        else if (sel_cl > (sel_cnt - 8'd1))
            sel_slot = sel_cnt - 8'd1;
        else
            sel_slot = sel_cl;
    end

    always_comb
    begin
        res_new.family = 3'd0;
        res_new.slot   = 8'd0;
        if (req_q_reg.rtype == TYPE_INVALID)
            res_new.status = STS_BAD_TYPE;
        else if (!sel_vld)
            res_new.status = STS_NO_FAMILY;
        else
        begin
            res_new.status = STS_OK;
            res_new.family = sel_idx_wide[2:0];
            res_new.slot   = sel_slot;
        end
    end

    // counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nfam_reg <= '0;
            nreq_reg <= '0;
        end
        else
        begin
            if (fam_load_ok)
                nfam_reg <= nfam_reg + FCW'(1);
            if (req_load_ok)
                nreq_reg <= nreq_reg + RCW'(1);
        end
    end

    // family store and claim counters
    always_ff @(posedge clk)
    begin
        if (fam_load_ok)
        begin
            fam_caps_reg[nfam_reg[FAW-1:0]] <= item.family_flags[2:0];
            fam_pc_reg[nfam_reg[FAW-1:0]]   <= popcount32(item.family_flags);
            fam_cnt_reg[nfam_reg[FAW-1:0]]  <= item.family_queue_count;
        end
        if (cmd.clear_claims)
        begin
            for (int k = 0; k < MAX_FAMILIES; k++)
            begin
                claimed_reg[k] <= 8'd0;
            end
        end
        else if (cmd.commit && (res_new.status == STS_OK))
            claimed_reg[sel_idx] <= sel_slot + 8'd1;
    end

    // request and result memories
    always_ff @(posedge clk)
    begin
        if (req_load_ok)
            req_mem[nreq_reg[RAW-1:0]] <= '{ded: item.prefer_dedicated,
                                           rtype: item.request_type};
        if (cmd.commit)
            res_mem[addr] <= res_new;
        if (cmd.rd)
        begin
            req_q_reg <= req_mem[addr];
            res_q_reg <= res_mem[addr];
        end
    end

    // best-fit trackers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_vld_reg  <= 1'b0;
            any_vld_reg <= 1'b0;
        end
        else if (cmd.scan_clear)
        begin
            sp_vld_reg  <= 1'b0;
            any_vld_reg <= 1'b0;
        end
        else if (cmd.scan_en)
        begin
            if (upd_sp)
                sp_vld_reg <= 1'b1;
            if (upd_any)
                any_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_en && upd_sp)
        begin
            sp_idx_reg <= fam_idx;
            sp_pc_reg  <= fam_pc_reg[fam_idx];
            sp_cl_reg  <= claimed_reg[fam_idx];
            sp_cnt_reg <= fam_cnt_reg[fam_idx];
        end
        if (cmd.scan_en && upd_any)
        begin
            any_idx_reg <= fam_idx;
            any_pc_reg  <= fam_pc_reg[fam_idx];
            any_cl_reg  <= claimed_reg[fam_idx];
            any_cnt_reg <= fam_cnt_reg[fam_idx];
        end
    end

    assign sts.have_reqs = (nreq_reg != '0);
    assign sts.last_req  = ((RCW'(addr) + RCW'(1)) == nreq_reg);
    assign sts.last_fam  = ((FCW'(fam_idx) + FCW'(1)) == nfam_reg);
    assign sts.req_ded   = req_q_reg.ded;
    assign sts.req_skip  = (req_q_reg.rtype == TYPE_INVALID) || (nfam_reg == '0);

    assign addr_wide = (RAW + 4)'(addr);

    assign result.request_index = addr_wide[3:0];
    assign result.queue_role    = req_q_reg.rtype;
    assign result.family_index  = res_q_reg.family;
    assign result.slot_index    = res_q_reg.slot;
    assign result.status        = res_q_reg.status;
    assign result.last          = sts.last_req;

endmodule

// File: rtl/qfbfa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfbfa_ctrl
// sequencer: loads, two resolve passes with family scan, result emission
// ----------------------------------------------------------------------------
module qfbfa_ctrl
    import qfbfa_pkg::*;
#(
    parameter int MAX_FAMILIES = MAX_FAMILIES_DEF,
    parameter int MAX_REQUESTS = MAX_REQUESTS_DEF,
    localparam int FAW = (MAX_FAMILIES > 1) ? $clog2(MAX_FAMILIES) : 1,
    localparam int RAW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  logic [1:0]     opcode,
    output logic           result_valid,
    input  logic           result_ready,
    input  dp_sts_t        sts,
    output ctrl_cmd_t      cmd,
    output logic [RAW-1:0] addr,
    output logic [FAW-1:0] fam_idx
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FETCH  = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;
    localparam logic [2:0] ST_NEXT   = 3'd5;
    localparam logic [2:0] ST_EFETCH = 3'd6;
    localparam logic [2:0] ST_EMIT   = 3'd7;

    logic [2:0]     state_reg, state_next;
    logic [RAW-1:0] req_reg, req_next;
    logic [FAW-1:0] fam_reg, fam_next;
    logic           pass_reg, pass_next;   // 1 while resolving dedicated requests
    logic           accept;

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = (state_reg == ST_EMIT);
    assign accept       = item_valid && item_ready;
    assign addr         = req_reg;
    assign fam_idx      = fam_reg;

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        fam_next   = fam_reg;
        pass_next  = pass_reg;
        cmd        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load_fam = accept && (opcode == OP_LOAD_FAMILY);
                cmd.load_req = accept && (opcode == OP_LOAD_REQUEST);
                if (accept && (opcode == OP_RESOLVE) && sts.have_reqs)
                begin
                    cmd.clear_claims = 1'b1;
                    req_next   = '0;
                    pass_next  = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (sts.req_ded == pass_reg)
                begin
                    cmd.scan_clear = 1'b1;
                    fam_next   = '0;
                    state_next = sts.req_skip ? ST_COMMIT : ST_SCAN;
                end
                else
                    state_next = ST_NEXT;
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (sts.last_fam)
                    state_next = ST_COMMIT;
                else
                    fam_next = fam_reg + FAW'(1);
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                if (!sts.last_req)
                begin
                    req_next   = req_reg + RAW'(1);
                    state_next = ST_FETCH;
                end
                else if (pass_reg)
                begin
                    req_next   = '0;
                    pass_next  = 1'b0;
                    state_next = ST_FETCH;
                end
                else
                begin
                    req_next   = '0;
                    state_next = ST_EFETCH;
                end
            end
            ST_EFETCH:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (result_ready)
                begin
                    if (sts.last_req)
                        state_next = ST_IDLE;
                    else
                    begin
                        req_next   = req_reg + RAW'(1);
                        state_next = ST_EFETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            req_reg   <= '0;
            fam_reg   <= '0;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            req_reg   <= req_next;
            fam_reg   <= fam_next;
            pass_reg  <= pass_next;
        end
    end

    // never take an item while a result is offered
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(item_ready && result_valid))
        else $error("item taken while a result is pending");

    // a scan only runs for a request that has a valid type and families
    a_scan_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !sts.req_skip)
        else $error("family scan for a skipped request");

    // a commit is always followed by the advance step
    a_commit_next: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT) |=> (state_reg == ST_NEXT))
        else $error("commit not followed by advance");

    // a taken result that is not the last one leads to the next fetch
    a_emit_more: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && !sts.last_req) |=> (state_reg == ST_EFETCH))
        else $error("emission stopped early");

endmodule

// File: rtl/queue_family_best_fit_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// queue_family_best_fit_allocator
// collects queue family descriptors and queue requests, then assigns each
// request the family with the fewest capability bits and a slot within it
// ----------------------------------------------------------------------------
//
//  channel   signals                           moves
//  -------   -------------------------------   -------------------------------
//  item      item_valid, item_ready, item      load family / load request /
//                                              resolve command
//  result    result_valid, result_ready,       one resolved request, in load
//            result                            order, last flags the end
//
//  an item is taken only while no resolve run is active
//  a resolve run resolves every request, in a dedicated pass then a second pass,
//  before the first result, with a family scan of one family a cycle; each
//  result is then a memory read, then an offer
//  the result side may stall for any time; the run holds until it is taken
//  reset clears the loaded counts; the family and request stores need no
//  clearing since only loaded entries are ever read
//
module queue_family_best_fit_allocator
    import qfbfa_pkg::*;
#(
    parameter int MAX_FAMILIES = MAX_FAMILIES_DEF,
    parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int FAW = (MAX_FAMILIES > 1) ? $clog2(MAX_FAMILIES) : 1;
    localparam int RAW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

    // commands and status between sequencer and datapath
    ctrl_cmd_t      cmd;
    dp_sts_t        sts;
    // request pointer (resolve and emission) and family scan pointer
    logic [RAW-1:0] addr;
    logic [FAW-1:0] fam_idx;

    // sequencer: load strobes, dedicated pass then the others, emission
    qfbfa_ctrl #(
        .MAX_FAMILIES (MAX_FAMILIES),
        .MAX_REQUESTS (MAX_REQUESTS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .opcode       (item.opcode),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .sts          (sts),
        .cmd          (cmd),
        .addr         (addr),
        .fam_idx      (fam_idx)
    );

    // datapath: stores, best-fit scan, slot claim, result fields
    qfbfa_dp #(
        .MAX_FAMILIES (MAX_FAMILIES),
        .MAX_REQUESTS (MAX_REQUESTS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .cmd     (cmd),
        .addr    (addr),
        .fam_idx (fam_idx),
        .sts     (sts),
        .result  (result)
    );

endmodule

// File: test/queue_family_best_fit_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// queue_family_best_fit_allocator_tb
// loads queue families and requests, fires resolve runs, and checks every
// grant against an in-bench prediction of the best-fit choice
// ----------------------------------------------------------------------------
module queue_family_best_fit_allocator_tb;
    import qfbfa_pkg::*;

    localparam int FAM_DEPTH = MAX_FAMILIES_DEF;
    localparam int REQ_DEPTH = MAX_REQUESTS_DEF;

    // opcode 3 has no meaning in the block, it must be swallowed silently
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 200;

    // ------------------------------------------------------------------------
    // grant predictor: mirrors the family and request stores, works out the
    // grants of a resolve run and holds them until the block hands them out
    // ------------------------------------------------------------------------
    class queue_grant_predictor_t;
        logic [31:0] fam_flags [FAM_DEPTH];
        logic [7:0]  fam_slots [FAM_DEPTH];
        logic [7:0]  claimed [FAM_DEPTH];
        int unsigned fam_count;
        logic [1:0]  req_role [REQ_DEPTH];
        logic        req_ded [REQ_DEPTH];
        int unsigned req_count;
        result_t     resolved [REQ_DEPTH];
        result_t     expected_grants [$];
        int unsigned mismatches;

        function new();
            fam_count   = 0;
            req_count   = 0;
            mismatches  = 0;
        endfunction

        // fewest capability bits wins, lowest index on ties
        function int pick_family(logic [31:0] need, bit want_spare);
            int best;
            int best_bits;
            best      = -1;
            best_bits = 0;
            for (int f = 0; f < fam_count; f++)
            begin
                if ((fam_flags[f] & need) != need)
                    continue;
                if (want_spare && claimed[f] >= fam_slots[f])
                    continue;
                if (best < 0 || $countones(fam_flags[f]) < best_bits)
                begin
                    best      = f;
                    best_bits = $countones(fam_flags[f]);
                end
            end
            return best;
        endfunction

        function void grant_one(int r);
            int         fam;
            logic [7:0] slot;
            resolved[r].family_index = '0;
            resolved[r].slot_index   = '0;
            if (req_role[r] == TYPE_INVALID)
            begin
                resolved[r].status = STS_BAD_TYPE;
                return;
            end
            fam = pick_family(32'd1 << req_role[r], 1'b1);
            if (fam < 0)
                fam = pick_family(32'd1 << req_role[r], 1'b0);
            if (fam < 0)
            begin
                resolved[r].status = STS_NO_FAMILY;
                return;
            end
            slot = claimed[fam];
            if (fam_slots[fam] == 8'd0)
                slot = 8'd0;
            else if (slot > fam_slots[fam] - 8'd1)
                slot = fam_slots[fam] - 8'd1;
            claimed[fam]             = slot + 8'd1;
            resolved[r].status       = STS_OK;
            resolved[r].family_index = 3'(fam);
            resolved[r].slot_index   = slot;
        endfunction

        function void resolve_all();
            for (int f = 0; f < FAM_DEPTH; f++)
                claimed[f] = '0;
            for (int r = 0; r < req_count; r++)
                if (req_ded[r])
                    grant_one(r);
            for (int r = 0; r < req_count; r++)
                if (!req_ded[r])
                    grant_one(r);
            for (int r = 0; r < req_count; r++)
            begin
                resolved[r].request_index = 4'(r);
                resolved[r].queue_role    = req_role[r];
                resolved[r].last          = (r + 1 == req_count);
                expected_grants = {expected_grants, resolved[r]};
            end
        endfunction

        function void take_item(item_t it);
            case (it.opcode)
                OP_LOAD_FAMILY:
                    if (fam_count < FAM_DEPTH)
                    begin
                        fam_flags[fam_count] = it.family_flags;
                        fam_slots[fam_count] = it.family_queue_count;
                        fam_count++;
                    end
                OP_LOAD_REQUEST:
                    if (req_count < REQ_DEPTH)
                    begin
                        req_role[req_count] = it.request_type;
                        req_ded[req_count]  = it.prefer_dedicated;
                        req_count++;
                    end
                OP_RESOLVE:
                    resolve_all();
                default:
                    ;
            endcase
        endfunction

        task report(input string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_grant(input result_t got);
            result_t want;
            if (expected_grants.size() == 0)
            begin
                report($sformatf("result for request %0d with none pending",
                                 got.request_index));
                return;
            end
            want = expected_grants.pop_front();
            if (got.request_index !== want.request_index)
                report($sformatf("request_index got %0d want %0d",
                                 got.request_index, want.request_index));
            if (got.queue_role !== want.queue_role)
                report($sformatf("req %0d queue_role got %0d want %0d",
                                 want.request_index, got.queue_role, want.queue_role));
            if (got.family_index !== want.family_index)
                report($sformatf("req %0d family_index got %0d want %0d",
                                 want.request_index, got.family_index, want.family_index));
            if (got.slot_index !== want.slot_index)
                report($sformatf("req %0d slot_index got %0d want %0d",
                                 want.request_index, got.slot_index, want.slot_index));
            if (got.status !== want.status)
                report($sformatf("req %0d status got %0d want %0d",
                                 want.request_index, got.status, want.status));
            if (got.last !== want.last)
                report($sformatf("req %0d last got %0d want %0d",
                                 want.request_index, got.last, want.last));
        endtask
    endclass

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    queue_grant_predictor_t grants = new();

    // sender burst bookkeeping: items left in the current burst
    int unsigned burst_left = 0;

    queue_family_best_fit_allocator uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop in case the block hangs; far beyond the slowest clean run
    initial
    begin
        #2_000_000;
        $display("queue_family_best_fit_allocator_tb: errors");
        $finish;
    end

    // every field random, so unused fields of an opcode toggle too
    function automatic item_t random_item(logic [1:0] op);
        item_t it;
        it.opcode             = op;
        it.family_flags       = $urandom();
        it.family_queue_count = 8'($urandom());
        it.request_type       = 2'($urandom());
        it.prefer_dedicated   = 1'($urandom());
        return it;
    endfunction

    // present one item and hold it until taken; between bursts the valid
    // may drop for a random gap, inside a burst the next item follows at once
    task automatic issue(input item_t it);
        int unsigned gap;
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        grants.take_item(it);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    task automatic send_family(input logic [31:0] flags, input logic [7:0] slots);
        item_t it;
        it = random_item(OP_LOAD_FAMILY);
        it.family_flags       = flags;
        it.family_queue_count = slots;
        issue(it);
    endtask

    task automatic send_request(input logic [1:0] role, input logic ded);
        item_t it;
        it = random_item(OP_LOAD_REQUEST);
        it.request_type     = role;
        it.prefer_dedicated = ded;
        issue(it);
    endtask

    task automatic send_op(input logic [1:0] op);
        issue(random_item(op));
    endtask

    // mostly few-bit masks so ties and exact matches are common, some full
    // 32-bit masks so the upper bits count toward the score
    function automatic logic [31:0] random_flags();
        case ($urandom_range(0, 3))
            0:       return 32'($urandom_range(0, 7));
            1:       return $urandom();
            default: return 32'($urandom_range(0, 7)) | (32'd1 << $urandom_range(3, 31));
        endcase
    endfunction

    // small counts force claims to run out and take the fallback search
    function automatic logic [7:0] random_slots();
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 3));
    endfunction

    // result side: mostly random ready, sometimes a stall with ready held low,
    // sometimes a long calm stretch with ready held high
    initial
    begin : result_sink
        int unsigned stall_left;
        int unsigned calm_left;
        logic        next_ready;
        result_ready = 1'b0;
        stall_left   = 0;
        calm_left    = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
                grants.check_grant(result);
            if (calm_left != 0)
            begin
                calm_left--;
                next_ready = 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                next_ready = 1'b0;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        calm_left  = $urandom_range(20, 80);
                        next_ready = 1'b1;
                    end
                    1, 2:
                    begin
                        stall_left = $urandom_range(1, 12);
                        next_ready = 1'b0;
                    end
                    default:
                        next_ready = ($urandom_range(0, 2) != 0);
                endcase
            end
            result_ready <= next_ready;
        end
    end

    initial
    begin : stimulus
        int unsigned pick;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // resolve with nothing loaded: no result at all
        send_op(OP_RESOLVE);
        // unused opcode is dropped
        send_op(OP_UNUSED);
        // no families yet: invalid type and no matching family
        send_request(TYPE_INVALID, 1'b0);
        send_request(TYPE_GRAPHICS, 1'b1);
        send_op(OP_RESOLVE);
        // all flags with zero slots, then a family that matches nothing
        send_family(32'hFFFF_FFFF, 8'd0);
        send_family(32'h0000_0000, 8'd255);
        send_request(TYPE_COMPUTE, 1'b0);
        send_request(TYPE_TRANSFER, 1'b1);
        send_op(OP_RESOLVE);
        // narrow families: compute-only with one slot, graphics+transfer wide
        send_family(32'h0000_0002, 8'd1);
        send_family(32'h0000_0005, 8'd255);
        send_request(TYPE_COMPUTE, 1'b1);
        send_request(TYPE_GRAPHICS, 1'b0);
        send_request(TYPE_COMPUTE, 1'b0);
        send_op(OP_RESOLVE);
        // repeated resolve starts again from cleared claims
        send_op(OP_RESOLVE);
        // same bit count as the 0x5 family: tie goes to the lower index
        send_family(32'h8000_0004, 8'd2);
        send_request(TYPE_TRANSFER, 1'b0);
        send_request(TYPE_TRANSFER, 1'b1);
        send_request(TYPE_TRANSFER, 1'b0);
        send_op(OP_RESOLVE);

        // random part: fills the remaining stores with resolves in between,
        // then keeps going with dropped loads and repeated resolves
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                send_op(OP_UNUSED);
            else if (pick < 30)
                send_op(OP_RESOLVE);
            else if (pick < 55)
                send_family(random_flags(), random_slots());
            else
                send_request(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end
        send_op(OP_RESOLVE);
        item_valid <= 1'b0;

        // drain the last run, then linger for any stray result
        while (grants.expected_grants.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        if (grants.mismatches == 0)
            $display("queue_family_best_fit_allocator_tb: clean");
        else
            $display("queue_family_best_fit_allocator_tb: errors");
        $finish;
    end

endmodule
